// File: design/sptg_pkg.sv
// Shared types, constants and helpers for the soft PWM and servo tick generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sptg_pkg;

    localparam int MOTOR_CHANNELS = 4;
    localparam int POWER_CHANNELS = 2;
    localparam int SERVO_CHANNELS = 8;
    localparam int DUTY_W         = 8;
    localparam int PWM_CNT_W      = 9;
    localparam int FRAME_W        = 10;

    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 16;

    localparam int FIFO_DEPTH     = 3;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 2;

    localparam logic [PWM_CNT_W-1:0] PWM_TOP    = 9'd255;
    localparam logic [FRAME_W-1:0]   FRAME_WRAP = 10'd520;
    localparam logic [FRAME_W-1:0]   FRAME_RISE = 10'd1;
    localparam logic [FRAME_W-1:0]   SERVO_MIN  = 10'd20;
    localparam logic [FRAME_W-1:0]   SERVO_MAX  = 10'd60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PWM_OFFSET,
        REG_MOTOR_DUTIES,
        REG_POWER_DUTIES,
        REG_SERVO_ENDS
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_PWM,
        PH_GAP,
        PH_SERVO
    } phase_t;

    typedef struct packed {
        logic pwm_step;
        logic servo_step;
    } step_ctrl_t;

    typedef struct packed {
        logic                      frame_start;
        logic [SERVO_CHANNELS-1:0] servo;
        logic [POWER_CHANNELS-1:0] power;
        logic [MOTOR_CHANNELS-1:0] motor;
    } result_t;

    // High while duty plus offset reaches the down counter; zero duty is always low.
    function automatic logic pwm_level(
        input logic [DUTY_W-1:0]    duty,
        input logic [DUTY_W-1:0]    offset,
        input logic [PWM_CNT_W-1:0] counter
    );
        logic [PWM_CNT_W-1:0] sum;
        begin
            sum = {1'b0, duty} + {1'b0, offset};
            pwm_level = (duty != '0) && (sum >= counter);
        end
    endfunction

endpackage

`default_nettype wire

// File: design/sptg_pwm.sv
// PWM slot: shared down counter and the motor and power pin levels.
// Depends on sptg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sptg_pwm (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire sptg_pkg::step_ctrl_t                        ctrl,
    input  wire logic [sptg_pkg::DUTY_W-1:0]                 offset,
    input  wire logic [sptg_pkg::MOTOR_CHANNELS*8-1:0]       motor_duties,
    input  wire logic [sptg_pkg::POWER_CHANNELS*8-1:0]       power_duties,
    output logic      [sptg_pkg::MOTOR_CHANNELS-1:0]         motor_next,
    output logic      [sptg_pkg::POWER_CHANNELS-1:0]         power_next
);
    import sptg_pkg::*;

    logic [PWM_CNT_W-1:0]      counter_reg;
    logic [PWM_CNT_W-1:0]      counter_next;
    logic [MOTOR_CHANNELS-1:0] motor_reg;
    logic [POWER_CHANNELS-1:0] power_reg;

    always_comb
    begin
        motor_next   = motor_reg;
        power_next   = power_reg;
        counter_next = counter_reg;
        if (ctrl.pwm_step)
        begin
            for (int n = 0; n < MOTOR_CHANNELS; n++)
            begin
                motor_next[n] = pwm_level(motor_duties[n*DUTY_W +: DUTY_W], offset,
                                          counter_reg);
            end
            for (int n = 0; n < POWER_CHANNELS; n++)
            begin
                power_next[n] = pwm_level(power_duties[n*DUTY_W +: DUTY_W], offset,
                                          counter_reg);
            end
            // reload at zero with top plus offset, else count down
            if (counter_reg == '0)
                counter_next = PWM_TOP + {1'b0, offset};
            else
                counter_next = counter_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= PWM_TOP;
            motor_reg   <= '0;
            power_reg   <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
            motor_reg   <= motor_next;
            power_reg   <= power_next;
        end
    end

endmodule

`default_nettype wire

// File: design/sptg_servo.sv
// Servo slot: frame counter and the servo pulse levels.
// Depends on sptg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sptg_servo (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire sptg_pkg::step_ctrl_t                   ctrl,
    input  wire logic [sptg_pkg::SERVO_CHANNELS*8-1:0]  servo_ends,
    output logic      [sptg_pkg::SERVO_CHANNELS-1:0]    servo_next,
    output logic                                        frame_start
);
    import sptg_pkg::*;

    logic [FRAME_W-1:0]        frame_reg;
    logic [FRAME_W-1:0]        frame_next;
    logic [SERVO_CHANNELS-1:0] servo_reg;
    logic                      in_window;

    assign in_window = (frame_reg >= SERVO_MIN) && (frame_reg <= SERVO_MAX);

    always_comb
    begin
        servo_next  = servo_reg;
        frame_next  = frame_reg;
        frame_start = 1'b0;
        if (ctrl.servo_step)
        begin
            frame_next = frame_reg + 1'b1;
            if (frame_reg == FRAME_WRAP)
            begin
                // wrap to zero, then advance like every other step
                frame_next = FRAME_RISE;
            end
            else if (frame_reg == FRAME_RISE)
            begin
                // raise every enabled servo, drop the disabled ones
                frame_start = 1'b1;
                for (int n = 0; n < SERVO_CHANNELS; n++)
                    servo_next[n] = (servo_ends[n*8 +: 8] != 8'd0);
            end
            else if (in_window)
            begin
                for (int n = 0; n < SERVO_CHANNELS; n++)
                begin
                    if ({{(FRAME_W-8){1'b0}}, servo_ends[n*8 +: 8]} == frame_reg)
                        servo_next[n] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            servo_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            servo_reg <= servo_next;
        end
    end

endmodule

`default_nettype wire

// File: design/sptg_out_fifo.sv
// Small result queue that decouples the update stage from the output stream.
// Depends on sptg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sptg_out_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire sptg_pkg::result_t                  push_data,
    output logic                                    valid,
    input  wire logic                               ready,
    output sptg_pkg::result_t                       data,
    output logic      [sptg_pkg::FIFO_CNT_W-1:0]    count
);
    import sptg_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg;
    logic [FIFO_PTR_W-1:0] wptr_next;
    logic [FIFO_PTR_W-1:0] rptr_reg;
    logic [FIFO_PTR_W-1:0] rptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && ready;
    assign data  = mem_reg[rptr_reg];
    assign count = count_reg;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = (wptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (count_reg == '0)) |=> (valid && (data == $past(push_data))))
        else $error("word pushed into empty queue not presented");

endmodule

`default_nettype wire

// File: design/soft_pwm_and_servo_tick_generator_core.sv
// Top level of the soft PWM and servo tick generator: config registers, tick
// divider, input register and result queue. Depends on sptg_pkg, sptg_pwm,
// sptg_servo and sptg_out_fifo.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata[0] tick, rest zero
//  m_axis    out        tvalid/tready          tdata motor, power, servo, frame_start
//  cfg       in         cfg_we (no ready)      cfg_index, cfg_data
//
// One word per cycle sustained while m_axis_tready stays high; a word's result passes
// the input register, then the update into the result queue, before it leaves.
// The three-entry result queue absorbs output stalls; s_axis_tready drops only
// when the input register and queue together hold three words.
// Reset clears config registers, tick phase, frame count, levels and sets the
// PWM counter to 255; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module soft_pwm_and_servo_tick_generator_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [sptg_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [0] tick
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [3:0] motor_pins, [5:4] power_pins, [13:6] servo_pins, [14] frame_start
    output logic      [sptg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [sptg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sptg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sptg_pkg::*;

    logic [DUTY_W-1:0]               offset_reg;
    logic [MOTOR_CHANNELS*8-1:0]     motor_duties_reg;
    logic [POWER_CHANNELS*8-1:0]     power_duties_reg;
    logic [SERVO_CHANNELS*8-1:0]     servo_ends_reg;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic                            in_valid_reg;
    logic                            tick_reg;
    step_ctrl_t                      step;
    logic                            s_accept;

    logic [MOTOR_CHANNELS-1:0]       motor_next;
    logic [POWER_CHANNELS-1:0]       power_next;
    logic [SERVO_CHANNELS-1:0]       servo_next;
    logic                            frame_start;
    result_t                         push_word;
    result_t                         out_word;
    logic [FIFO_CNT_W-1:0]           fifo_count;
    logic [FIFO_CNT_W:0]             occupancy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            motor_duties_reg <= '0;
            power_duties_reg <= '0;
            servo_ends_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PWM_OFFSET:   offset_reg       <= cfg_data[DUTY_W-1:0];
                REG_MOTOR_DUTIES: motor_duties_reg <= cfg_data[MOTOR_CHANNELS*8-1:0];
                REG_POWER_DUTIES: power_duties_reg <= cfg_data[POWER_CHANNELS*8-1:0];
                REG_SERVO_ENDS:   servo_ends_reg   <= cfg_data[SERVO_CHANNELS*8-1:0];
                default:          ;
            endcase
        end
    end

    // input register; every held word drains into the queue next cycle
    assign occupancy     = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, in_valid_reg};
    assign s_axis_tready = (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= s_accept;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            tick_reg <= s_axis_tdata[0];
    end

    // tick divider: slot 0 runs PWM, slot 1 idles, slot 2 runs servo
    always_comb
    begin
        step       = '0;
        phase_next = phase_reg;
        if (in_valid_reg && tick_reg)
        begin
            case (phase_reg)
                PH_PWM:
                begin
                    step.pwm_step = 1'b1;
                    phase_next    = PH_GAP;
                end
                PH_GAP:
                begin
                    phase_next = PH_SERVO;
                end
                default:
                begin
                    step.servo_step = 1'b1;
                    phase_next      = PH_PWM;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_PWM;
        else
            phase_reg <= phase_next;
    end

    sptg_pwm u_pwm (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (step),
        .offset       (offset_reg),
        .motor_duties (motor_duties_reg),
        .power_duties (power_duties_reg),
        .motor_next   (motor_next),
        .power_next   (power_next)
    );

    sptg_servo u_servo (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (step),
        .servo_ends  (servo_ends_reg),
        .servo_next  (servo_next),
        .frame_start (frame_start)
    );

    always_comb
    begin
        push_word.frame_start = frame_start;
        push_word.servo       = servo_next;
        push_word.power       = power_next;
        push_word.motor       = motor_next;
    end

    sptg_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid_reg),
        .push_data (push_word),
        .valid     (m_axis_tvalid),
        .ready     (m_axis_tready),
        .data      (out_word),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_word};

    a_pwm_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
        step.pwm_step |=> (phase_reg == PH_GAP))
        else $error("phase did not move on after PWM slot");

    a_servo_then_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        step.servo_step |=> (phase_reg == PH_PWM))
        else $error("phase did not wrap after servo slot");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("more words in flight than queue entries");

    a_start_only_servo: assert property (@(posedge clk) disable iff (!rst_n)
        push_word.frame_start |-> (in_valid_reg && step.servo_step))
        else $error("frame start outside a servo slot");

endmodule

`default_nettype wire
